/* src/newton_square_root_assert.svh */
// ----------------------------------------------------------------------------
// newton square root assertion macros
// shared property forms used by the rtl modules
// ----------------------------------------------------------------------------
`ifndef NEWTON_SQUARE_ROOT_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsr assertion failed: implication");

// next-cycle implication, checked out of reset
`define NSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsr assertion failed: next-cycle implication");

`endif

/* src/nsr_pkg.sv */
// ----------------------------------------------------------------------------
// nsr_pkg
// shared types and constants of the newton square root block
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int RAD_W          = 32;  // radicand width
    localparam int MAG_W          = 31;  // magnitude of a non-negative radicand
    localparam int GUESS_W        = 32;  // newton guess width
    localparam int ROOT_W         = 25;  // result width
    localparam int QUEUE_DEPTH    = 2;
    localparam int DEF_ITERATIONS = 100;
    localparam int DEF_FRAC_BITS  = 16;

    typedef enum logic [1:0] {
        CLS_POS,
        CLS_ZERO,
        CLS_NEG
    } t_class;

    typedef struct packed {
        t_class             cls;
        logic [MAG_W-1:0]   mag;
    } t_item;

endpackage

/* src/newton_square_root.sv */
// throughput: one word per cycle while the result register is not held;
// every newton iteration has its own divider cells
// the iteration pipeline stalls as a whole only when the result register is held
// reset: synchronous active-low i_rst_n clears all valid flags and queue pointers
// ----------------------------------------------------------------------------
// newton_square_root
// pipelined fixed-point newton-raphson square root
// ----------------------------------------------------------------------------
module newton_square_root
    import nsr_pkg::*;
#(
    parameter int ITERATIONS    = DEF_ITERATIONS,
    parameter int FRACTION_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [RAD_W-1:0]  i_radicand,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [ROOT_W-1:0] o_root,
    output logic                     o_negative_error
);

    // front: register the word and tag negative, zero or positive
    t_item w_front_item;
    logic  w_front_valid;
    logic  w_front_ready;

    // queue to back: lets the classifier keep taking words in a stall until full
    t_item w_back_item;
    logic  w_back_valid;
    logic  w_back_ready;

    nsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_radicand (i_radicand),
        .o_valid    (w_front_valid),
        .i_ready    (w_front_ready),
        .o_item     (w_front_item)
    );

    nsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_item  (w_front_item),
        .o_valid (w_back_valid),
        .i_ready (w_back_ready),
        .o_item  (w_back_item)
    );

    // back: one divide-and-average cell per iteration, then clamp and register
    nsr_back #(
        .ITERATIONS    (ITERATIONS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_back_valid),
        .o_ready          (w_back_ready),
        .i_item           (w_back_item),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_root           (o_root),
        .o_negative_error (o_negative_error)
    );

endmodule

/* src/nsr_front.sv */
// ----------------------------------------------------------------------------
// nsr_front
// accepts radicand words and tags them negative, zero or positive
// ----------------------------------------------------------------------------
module nsr_front
    import nsr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [RAD_W-1:0] i_radicand,
    output logic             o_valid,
    input  logic             i_ready,
    output t_item            o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.mag = i_radicand[MAG_W-1:0];
        if (i_radicand[RAD_W-1]) begin
            n_item.cls = CLS_NEG;
        end else if (i_radicand == '0) begin
            n_item.cls = CLS_ZERO;
        end else begin
            n_item.cls = CLS_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

/* src/nsr_queue.sv */
// ----------------------------------------------------------------------------
// nsr_queue
// short fifo between the classifier and the iteration pipeline
// ----------------------------------------------------------------------------
`include "newton_square_root_assert.svh"

module nsr_queue
    import nsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `NSR_ASSERT_IMPLY(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(QUEUE_DEPTH))
    `NSR_ASSERT_NEXT(a_fill, i_clk, i_rst_n, w_push && !w_pop, o_valid)
    `NSR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

endmodule

/* src/nsr_step.sv */
// ----------------------------------------------------------------------------
// nsr_step
// one newton iteration: a bit-per-stage restoring divider, then the average
// ----------------------------------------------------------------------------
module nsr_step
    import nsr_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  t_class                           i_cls,
    input  logic [MAG_W+FRACTION_BITS-1:0]   i_num,
    input  logic [GUESS_W-1:0]               i_guess,
    output logic                             o_valid,
    output t_class                           o_cls,
    output logic [MAG_W+FRACTION_BITS-1:0]   o_num,
    output logic [GUESS_W-1:0]               o_guess
);

    localparam int NW = MAG_W + FRACTION_BITS;

    // stage inputs: index 0 is the step input, index k+1 the k-th register
    logic               s_vld [NW+1];
    t_class             s_cls [NW+1];
    logic [NW-1:0]      s_num [NW+1];
    logic [GUESS_W-1:0] s_g   [NW+1];
    logic [GUESS_W-1:0] s_d   [NW+1];
    logic [GUESS_W-1:0] s_rem [NW+1];
    logic [NW-1:0]      s_quo [NW+1];

    logic               r_vld;
    t_class             r_cls;
    logic [NW-1:0]      r_num;
    logic [GUESS_W-1:0] r_g;
    logic [NW:0]        n_sum;

    assign s_vld[0] = i_valid;
    assign s_cls[0] = i_cls;
    assign s_num[0] = i_num;
    assign s_g[0]   = i_guess;
    assign s_d[0]   = (i_guess == '0) ? GUESS_W'(1) : i_guess;
    assign s_rem[0] = '0;
    assign s_quo[0] = '0;

    for (genvar k = 0; k < NW; k++) begin : g_div
        logic               r_vld_k;
        t_class             r_cls_k;
        logic [NW-1:0]      r_num_k;
        logic [GUESS_W-1:0] r_g_k;
        logic [GUESS_W-1:0] r_d_k;
        logic [GUESS_W-1:0] r_rem_k;
        logic [NW-1:0]      r_quo_k;
        logic [GUESS_W:0]   n_trial;
        logic [GUESS_W:0]   n_diff;
        logic               n_ge;

        always_comb begin
            n_trial = {s_rem[k], s_num[k][NW-1-k]};
            n_diff  = n_trial - {1'b0, s_d[k]};
            n_ge    = (n_trial >= {1'b0, s_d[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_k <= 1'b0;
            end else if (i_en) begin
                r_vld_k <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cls_k <= s_cls[k];
                r_num_k <= s_num[k];
                r_g_k   <= s_g[k];
                r_d_k   <= s_d[k];
                r_rem_k <= n_ge ? n_diff[GUESS_W-1:0] : n_trial[GUESS_W-1:0];
                r_quo_k <= {s_quo[k][NW-2:0], n_ge};
            end
        end

        assign s_vld[k+1] = r_vld_k;
        assign s_cls[k+1] = r_cls_k;
        assign s_num[k+1] = r_num_k;
        assign s_g[k+1]   = r_g_k;
        assign s_d[k+1]   = r_d_k;
        assign s_rem[k+1] = r_rem_k;
        assign s_quo[k+1] = r_quo_k;
    end

    // remainder of the last stage is not needed
    assign n_sum = (NW+1)'(s_g[NW]) + (NW+1)'(s_quo[NW]) + (NW+1)'(s_rem[NW] & '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= s_vld[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cls <= s_cls[NW];
            r_num <= s_num[NW];
            r_g   <= GUESS_W'(n_sum >> 1);
        end
    end

    assign o_valid = r_vld;
    assign o_cls   = r_cls;
    assign o_num   = r_num;
    assign o_guess = r_g;

endmodule

/* src/nsr_back.sv */
// ----------------------------------------------------------------------------
// nsr_back
// chain of newton iteration cells, final saturation and the result register
// ----------------------------------------------------------------------------
`include "newton_square_root_assert.svh"

module nsr_back
    import nsr_pkg::*;
#(
    parameter int ITERATIONS    = DEF_ITERATIONS,
    parameter int FRACTION_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_item                    i_item,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [ROOT_W-1:0] o_root,
    output logic                     o_negative_error
);

    localparam int NW = MAG_W + FRACTION_BITS;
    localparam logic [ROOT_W:0] NEG_MAG = (FRACTION_BITS >= ROOT_W - 1)
        ? (ROOT_W+1)'(1) << (ROOT_W - 1) : (ROOT_W+1)'(1) << FRACTION_BITS;
    localparam logic [ROOT_W-1:0] NEG_ROOT = ROOT_W'(~NEG_MAG + 1'b1);
    localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};

    logic               c_vld [ITERATIONS+1];
    t_class             c_cls [ITERATIONS+1];
    logic [NW-1:0]      c_num [ITERATIONS+1];
    logic [GUESS_W-1:0] c_g   [ITERATIONS+1];

    logic               w_en;
    logic               r_out_valid;
    logic [ROOT_W-1:0]  r_out_root;
    logic               r_out_err;
    logic [ROOT_W-1:0]  n_root;
    logic               n_err;
    logic [GUESS_W-1:0] w_final;

    // whole pipeline advances unless the result register is full and stalled
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    assign c_vld[0] = i_valid;
    assign c_cls[0] = i_item.cls;
    assign c_num[0] = NW'(i_item.mag) << FRACTION_BITS;
    assign c_g[0]   = GUESS_W'(i_item.mag);

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        nsr_step #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (c_vld[i]),
            .i_cls   (c_cls[i]),
            .i_num   (c_num[i]),
            .i_guess (c_g[i]),
            .o_valid (c_vld[i+1]),
            .o_cls   (c_cls[i+1]),
            .o_num   (c_num[i+1]),
            .o_guess (c_g[i+1])
        );
    end

    assign w_final = c_g[ITERATIONS];

    always_comb begin
        unique case (c_cls[ITERATIONS])
            CLS_NEG: begin
                n_root = NEG_ROOT;
                n_err  = 1'b1;
            end
            CLS_ZERO: begin
                n_root = '0;
                n_err  = 1'b0;
            end
            default: begin
                // clamp an oversized guess to the largest positive result
                n_root = (w_final[GUESS_W-1:ROOT_W-1] != '0)
                    ? ROOT_MAX : {1'b0, w_final[ROOT_W-2:0]};
                n_err  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= c_vld[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_root <= n_root;
            r_out_err  <= n_err;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_root           = r_out_root;
    assign o_negative_error = r_out_err;

    `NSR_ASSERT_IMPLY(a_neg_value, i_clk, i_rst_n, r_out_valid && r_out_err, r_out_root == NEG_ROOT)
    `NSR_ASSERT_IMPLY(a_pos_sign, i_clk, i_rst_n, r_out_valid && !r_out_err, !r_out_root[ROOT_W-1])
    `NSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_ready, r_out_valid)

endmodule
